// ----- src/hcc_pkg.sv -----
package hcc_pkg;

    localparam int unsigned DOUBLE_ROUNDS = 10;
    // each column or diagonal pass is split into two register stages
    localparam int unsigned PIPE_STAGES   = DOUBLE_ROUNDS * 4;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned STATE_WORDS   = 16;

    localparam int unsigned ROT_A = 16;
    localparam int unsigned ROT_B = 12;
    localparam int unsigned ROT_C = 8;
    localparam int unsigned ROT_D = 7;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [STATE_WORDS-1:0] t_state;

    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    typedef struct packed {
        t_word key_word_0;
        t_word key_word_1;
        t_word key_word_2;
        t_word key_word_3;
        t_word key_word_4;
        t_word key_word_5;
        t_word key_word_6;
        t_word key_word_7;
        t_word nonce_word_0;
        t_word nonce_word_1;
        t_word nonce_word_2;
        t_word nonce_word_3;
    } t_in;

    typedef struct packed {
        t_word subkey_word_0;
        t_word subkey_word_1;
        t_word subkey_word_2;
        t_word subkey_word_3;
        t_word subkey_word_4;
        t_word subkey_word_5;
        t_word subkey_word_6;
        t_word subkey_word_7;
    } t_out;

    // per-stage control: diagonal or column pass, second or first half of the quarter round
    typedef struct packed {
        logic diag;
        logic second;
    } t_stage_ctl;

    function automatic t_word rotl(input t_word v, input int unsigned s);
        t_word res;
        res = (v << s) | (v >> (WORD_W - s));
        return res;
    endfunction

endpackage

// ----- src/hcc_round_stage.sv -----
module hcc_round_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hcc_pkg::t_stage_ctl i_ctl,
    input  logic                i_valid,
    input  hcc_pkg::t_state     i_state,
    output logic                o_valid,
    output hcc_pkg::t_state     o_state
);
    import hcc_pkg::*;

    t_word  w_a [4];
    t_word  w_b [4];
    t_word  w_c [4];
    t_word  w_d [4];
    t_word  w_a2 [4];
    t_word  w_b2 [4];
    t_word  w_c2 [4];
    t_word  w_d2 [4];
    t_state n_state;
    t_state r_state;
    logic   r_valid;

    for (genvar j = 0; j < 4; j++) begin : g_lane
        // gather lane words; diagonal pass shifts rows 1..3 by 1..3 columns
        assign w_a[j] = i_state[j];
        assign w_b[j] = i_ctl.diag ? i_state[4 + (j + 1) % 4]  : i_state[4 + j];
        assign w_c[j] = i_ctl.diag ? i_state[8 + (j + 2) % 4]  : i_state[8 + j];
        assign w_d[j] = i_ctl.diag ? i_state[12 + (j + 3) % 4] : i_state[12 + j];

        always_comb begin
            t_word sum_a;
            t_word sum_c;
            sum_a    = w_a[j] + w_b[j];
            w_d2[j]  = i_ctl.second ? rotl(w_d[j] ^ sum_a, ROT_C)
                                    : rotl(w_d[j] ^ sum_a, ROT_A);
            sum_c    = w_c[j] + w_d2[j];
            w_b2[j]  = i_ctl.second ? rotl(w_b[j] ^ sum_c, ROT_D)
                                    : rotl(w_b[j] ^ sum_c, ROT_B);
            w_a2[j]  = sum_a;
            w_c2[j]  = sum_c;
        end

        // scatter back to state positions
        assign n_state[j]      = w_a2[j];
        assign n_state[4 + j]  = i_ctl.diag ? w_b2[(j + 3) % 4] : w_b2[j];
        assign n_state[8 + j]  = i_ctl.diag ? w_c2[(j + 2) % 4] : w_c2[j];
        assign n_state[12 + j] = i_ctl.diag ? w_d2[(j + 1) % 4] : w_d2[j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

// ----- src/hchacha20_subkey_derivation.sv -----
// pipeline: each accepted item passes through the register stages in order to o_done
// (two register stages per column or diagonal pass, ten double rounds)
// throughput: one derivation per cycle; busy is never raised
// reset: synchronous active-low i_rst_n clears all stage valid bits; data is not reset
// results cannot be held off, o_done lasts one cycle per item
module hchacha20_subkey_derivation (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hcc_pkg::t_in  i_item,
    output logic          o_done,
    output hcc_pkg::t_out o_result
);
    import hcc_pkg::*;

    logic   w_valid [PIPE_STAGES+1];
    t_state w_state [PIPE_STAGES+1];

    assign busy = 1'b0;

    assign w_valid[0] = start & ~busy;
    assign w_state[0] = {i_item.nonce_word_3, i_item.nonce_word_2,
                         i_item.nonce_word_1, i_item.nonce_word_0,
                         i_item.key_word_7,   i_item.key_word_6,
                         i_item.key_word_5,   i_item.key_word_4,
                         i_item.key_word_3,   i_item.key_word_2,
                         i_item.key_word_1,   i_item.key_word_0,
                         SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};

    for (genvar g = 0; g < PIPE_STAGES; g++) begin : g_stage
        t_stage_ctl w_ctl;
        assign w_ctl.diag   = 1'((g / 2) % 2);
        assign w_ctl.second = 1'(g % 2);

        hcc_round_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1])
        );
    end

    assign o_done                  = w_valid[PIPE_STAGES];
    assign o_result.subkey_word_0  = w_state[PIPE_STAGES][0];
    assign o_result.subkey_word_1  = w_state[PIPE_STAGES][1];
    assign o_result.subkey_word_2  = w_state[PIPE_STAGES][2];
    assign o_result.subkey_word_3  = w_state[PIPE_STAGES][3];
    assign o_result.subkey_word_4  = w_state[PIPE_STAGES][12];
    assign o_result.subkey_word_5  = w_state[PIPE_STAGES][13];
    assign o_result.subkey_word_6  = w_state[PIPE_STAGES][14];
    assign o_result.subkey_word_7  = w_state[PIPE_STAGES][15];

    // every strobe traces back to an earlier transfer at the pipeline entry
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_STAGES))
        else $error("result strobe without matching transfer");

    // a transfer enters the first stage on the next edge
    a_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> w_valid[1])
        else $error("transfer lost at pipeline entry");

    // no item is dropped in the second half of the pipeline
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[PIPE_STAGES/2] |-> ##(PIPE_STAGES/2) o_done)
        else $error("item dropped in pipeline");

endmodule
